@@ hdl/lwlrb_pkg.sv @@
// Shared constants, types and pointer helpers for the line-wrapping log ring buffer.
// No dependencies; used by lwlrb_cfg and line_wrapping_log_ring_buffer_unit.
package lwlrb_pkg;

    localparam int STORE_DEPTH = 2048;
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int FW = $clog2(STORE_DEPTH + 1);

    typedef logic [AW-1:0] ptr_t;
    typedef logic [FW-1:0] cnt_t;
    typedef logic [FW:0]   sum_t;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_COUNT  = 2'd1;
    localparam logic [1:0] KIND_FETCH  = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FILTERED  = 2'd2;

    localparam logic [6:0] MAX_ROOM    = 7'd64;
    localparam logic [7:0] WRAP_RESET  = 8'd64;
    localparam logic       REG_WRAP    = 1'b0;

    function automatic ptr_t ptr_next(input ptr_t p);
        ptr_t r;
        if (p == ptr_t'(STORE_DEPTH - 1))
            r = '0;
        else
            r = p + ptr_t'(1);
        return r;
    endfunction

    function automatic ptr_t oldest_pos(input ptr_t wp, input cnt_t fill);
        sum_t s;
        s = sum_t'(wp) + sum_t'(STORE_DEPTH) - sum_t'(fill);
        if (s >= sum_t'(STORE_DEPTH))
            s = s - sum_t'(STORE_DEPTH);
        return ptr_t'(s);
    endfunction

endpackage

@@ hdl/lwlrb_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lwlrb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/lwlrb_cfg.sv @@
// APB register file: holds the wrap length register.
// Depends on lwlrb_pkg.
module lwlrb_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  wrap_length
);

    logic [7:0] wrap_reg;
    logic [7:0] wrap_next;
    logic       sel_wrap;

    assign pready   = 1'b1;
    assign sel_wrap = (paddr[2] == lwlrb_pkg::REG_WRAP);

    always_comb
    begin
        wrap_next = wrap_reg;
        if (psel && penable && pwrite && pready && sel_wrap)
        begin
            wrap_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_reg <= lwlrb_pkg::WRAP_RESET;
        end
        else
        begin
            wrap_reg <= wrap_next;
        end
    end

    assign prdata      = sel_wrap ? {24'd0, wrap_reg} : 32'd0;
    assign wrap_length = wrap_reg;

endmodule

@@ hdl/line_wrapping_log_ring_buffer_unit.sv @@
// Line-wrapping circular character log: sequencer around the byte store.
// Depends on lwlrb_pkg, lwlrb_ram and lwlrb_cfg.
//
// Usage:
//   Present kind, char_in, line_index and max_chars with start high; the item
//   transfers at a rising edge with start high and busy low. Each result shows
//   for one cycle with done high, last marks the final result of an item. The
//   receiver cannot stall; results are never held back.
//   Append: one store write per cycle; when a continuation break (backslash,
//   line feed) goes in, it follows the character through ST_BS and ST_LF.
//   A plain append, a filtered character or an unused kind answers from idle.
//   Count: the store read port scans the whole fill, one byte a cycle.
//   Fetch: the store is scanned for the wanted line; characters come out one
//   per cycle back to back, followed by the terminator.
//   Results appear at the edge after the last cycle of the item.
//   wrap_length lives at APB address 0; the user writes it only while busy
//   is low; the block does not enforce this. Reset empties the log (pointer,
//   fill, line length cleared) and sets wrap_length to 64; store not cleared.
module line_wrapping_log_ring_buffer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [7:0]  char_in,
    input  logic [10:0] line_index,
    input  logic [6:0]  max_chars,
    output logic        done,
    output logic [1:0]  status,
    output logic [7:0]  char_out,
    output logic [11:0] line_total,
    output logic        newline_event,
    output logic        last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BS   = 2'd1;
    localparam logic [1:0] ST_LF   = 2'd2;
    localparam logic [1:0] ST_WALK = 2'd3;

    logic [7:0] wrap_length;

    logic [1:0]          state_reg, state_next;
    lwlrb_pkg::ptr_t     wp_reg, wp_next;
    lwlrb_pkg::cnt_t     fill_reg, fill_next;
    logic [7:0]          len_reg, len_next;
    logic                fetch_reg, fetch_next;
    logic [10:0]         want_reg, want_next;
    logic [6:0]          room_reg, room_next;
    lwlrb_pkg::ptr_t     ip_reg, ip_next;
    lwlrb_pkg::cnt_t     issue_left_reg, issue_left_next;
    lwlrb_pkg::cnt_t     left_reg, left_next;
    logic                rv_reg, rv_next;
    logic                phase_reg, phase_next;
    logic [10:0]         line_reg, line_next;
    logic [6:0]          n_reg, n_next;
    lwlrb_pkg::cnt_t     total_reg, total_next;

    logic                done_reg, done_next;
    logic [1:0]          status_reg, status_next;
    logic [7:0]          char_reg, char_next;
    logic [11:0]         ltot_reg, ltot_next;
    logic                nl_reg, nl_next;
    logic                last_reg, last_next;

    logic                wr_en;
    lwlrb_pkg::ptr_t     wr_addr;
    logic [7:0]          wr_data;
    logic                rd_en;
    logic [7:0]          rd_data;
    logic                rd_lf;
    logic [7:0]          len_inc;
    logic [10:0]         line_inc;
    lwlrb_pkg::cnt_t     fill_sat;
    lwlrb_pkg::cnt_t     total_inc;

    lwlrb_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .wrap_length (wrap_length)
    );

    lwlrb_ram #(
        .DATA_W (8),
        .DEPTH  (lwlrb_pkg::STORE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (ip_reg),
        .rd_data (rd_data)
    );

    assign busy      = (state_reg != ST_IDLE);
    assign rd_lf     = (rd_data == lwlrb_pkg::CH_LF);
    assign len_inc   = len_reg + 8'd1;
    assign line_inc  = line_reg + 11'(rd_lf);
    assign total_inc = total_reg + lwlrb_pkg::cnt_t'(rd_lf);
    assign fill_sat  = (fill_reg == lwlrb_pkg::cnt_t'(lwlrb_pkg::STORE_DEPTH)) ?
                       fill_reg : fill_reg + lwlrb_pkg::cnt_t'(1);

    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        fill_next       = fill_reg;
        len_next        = len_reg;
        fetch_next      = fetch_reg;
        want_next       = want_reg;
        room_next       = room_reg;
        ip_next         = ip_reg;
        issue_left_next = issue_left_reg;
        left_next       = left_reg;
        rv_next         = 1'b0;
        phase_next      = phase_reg;
        line_next       = line_reg;
        n_next          = n_reg;
        total_next      = total_reg;

        done_next   = 1'b0;
        status_next = lwlrb_pkg::STAT_OK;
        char_next   = 8'd0;
        ltot_next   = 12'd0;
        nl_next     = 1'b0;
        last_next   = 1'b0;

        wr_en   = 1'b0;
        wr_addr = wp_reg;
        wr_data = char_in;
        rd_en   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ip_next         = lwlrb_pkg::oldest_pos(wp_reg, fill_reg);
                    issue_left_next = fill_reg;
                    left_next       = fill_reg;
                    total_next      = '0;
                    line_next       = '0;
                    n_next          = '0;
                    want_next       = line_index;
                    phase_next      = (line_index == 11'd0);
                    room_next       = (max_chars > lwlrb_pkg::MAX_ROOM) ?
                                      lwlrb_pkg::MAX_ROOM : max_chars;
                    case (kind)
                        lwlrb_pkg::KIND_APPEND:
                        begin
                            done_next = 1'b1;
                            last_next = 1'b1;
                            if (char_in != lwlrb_pkg::CH_LF && char_in < lwlrb_pkg::CH_SPACE)
                            begin
                                status_next = lwlrb_pkg::STAT_FILTERED;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                wp_next   = lwlrb_pkg::ptr_next(wp_reg);
                                fill_next = fill_sat;
                                if (char_in == lwlrb_pkg::CH_LF)
                                begin
                                    len_next = 8'd0;
                                    nl_next  = 1'b1;
                                end
                                else if (len_inc >= wrap_length)
                                begin
                                    len_next   = 8'd0;
                                    done_next  = 1'b0;
                                    last_next  = 1'b0;
                                    state_next = ST_BS;
                                end
                                else
                                begin
                                    len_next = len_inc;
                                end
                            end
                        end
                        lwlrb_pkg::KIND_COUNT:
                        begin
                            fetch_next = 1'b0;
                            if (fill_reg == '0)
                            begin
                                done_next = 1'b1;
                                last_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_WALK;
                            end
                        end
                        lwlrb_pkg::KIND_FETCH:
                        begin
                            fetch_next = 1'b1;
                            if (max_chars == 7'd0 || (fill_reg == '0 && line_index != 11'd0))
                            begin
                                done_next   = 1'b1;
                                last_next   = 1'b1;
                                status_next = lwlrb_pkg::STAT_NOT_FOUND;
                            end
                            else if (fill_reg == '0)
                            begin
                                done_next = 1'b1;
                                last_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            last_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_BS:
            begin
                wr_en      = 1'b1;
                wr_data    = lwlrb_pkg::CH_BSLASH;
                wp_next    = lwlrb_pkg::ptr_next(wp_reg);
                fill_next  = fill_sat;
                state_next = ST_LF;
            end
            ST_LF:
            begin
                wr_en      = 1'b1;
                wr_data    = lwlrb_pkg::CH_LF;
                wp_next    = lwlrb_pkg::ptr_next(wp_reg);
                fill_next  = fill_sat;
                done_next  = 1'b1;
                last_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                if (issue_left_reg != '0)
                begin
                    rd_en           = 1'b1;
                    ip_next         = lwlrb_pkg::ptr_next(ip_reg);
                    issue_left_next = issue_left_reg - lwlrb_pkg::cnt_t'(1);
                    rv_next         = 1'b1;
                end
                if (!fetch_reg)
                begin
                    if (rv_reg)
                    begin
                        total_next = total_inc;
                        left_next  = left_reg - lwlrb_pkg::cnt_t'(1);
                        if (left_reg == lwlrb_pkg::cnt_t'(1))
                        begin
                            done_next  = 1'b1;
                            last_next  = 1'b1;
                            ltot_next  = 12'(total_inc);
                            state_next = ST_IDLE;
                        end
                    end
                end
                else if (!phase_reg)
                begin
                    if (rv_reg)
                    begin
                        left_next = left_reg - lwlrb_pkg::cnt_t'(1);
                        line_next = line_inc;
                        if (rd_lf && line_inc == want_reg)
                        begin
                            phase_next = 1'b1;
                        end
                        else if (left_reg == lwlrb_pkg::cnt_t'(1))
                        begin
                            done_next   = 1'b1;
                            last_next   = 1'b1;
                            status_next = lwlrb_pkg::STAT_NOT_FOUND;
                            state_next  = ST_IDLE;
                        end
                    end
                end
                else if (left_reg == '0 || (n_reg + 7'd1) >= room_reg)
                begin
                    done_next  = 1'b1;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (rv_reg)
                begin
                    done_next = 1'b1;
                    if (rd_lf)
                    begin
                        last_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        char_next = rd_data;
                        n_next    = n_reg + 7'd1;
                        left_next = left_reg - lwlrb_pkg::cnt_t'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg    <= '0;
            fill_reg  <= '0;
            len_reg   <= 8'd0;
            rv_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            rv_reg    <= rv_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fetch_reg      <= fetch_next;
        want_reg       <= want_next;
        room_reg       <= room_next;
        ip_reg         <= ip_next;
        issue_left_reg <= issue_left_next;
        left_reg       <= left_next;
        phase_reg      <= phase_next;
        line_reg       <= line_next;
        n_reg          <= n_next;
        total_reg      <= total_next;
        status_reg     <= status_next;
        char_reg       <= char_next;
        ltot_reg       <= ltot_next;
        nl_reg         <= nl_next;
        last_reg       <= last_next;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign char_out      = char_reg;
    assign line_total    = ltot_reg;
    assign newline_event = nl_reg;
    assign last          = last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= lwlrb_pkg::cnt_t'(lwlrb_pkg::STORE_DEPTH))
        else $error("fill count above store depth");

    a_fetch_burst: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !last_reg |=> done_reg)
        else $error("gap inside fetch result burst");

    a_burst_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !last_reg |-> state_reg == ST_WALK)
        else $error("partial result outside a store walk");

    a_filtered: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg == lwlrb_pkg::STAT_FILTERED |-> last_reg && !nl_reg)
        else $error("filtered result malformed");

endmodule
